/* src/ustc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ustc_pkg
// Shared widths, constants, types and tables for the seconds-to-civil
// converter pipeline.
// ----------------------------------------------------------------------------
package ustc_pkg;

    // field widths
    localparam int SEC_W   = 32;
    localparam int DAYS_W  = 16;
    localparam int TOD_W   = 17;
    localparam int YEAR_W  = 12;
    localparam int MON_W   = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SECF_W  = 6;

    // days = (ts >> 7) / 675, reciprocal floor(2^35 / 675)
    localparam logic [25:0] DAY_RECIP  = 26'd50903316;
    localparam logic [9:0]  DAY_DIV    = 10'd675;

    // hour = (tod >> 4) / 225, reciprocal floor(2^16 / 225)
    localparam logic [8:0]  HOUR_RECIP = 9'd291;
    localparam logic [11:0] SECS_HOUR  = 12'd3600;

    // minute = (rem >> 2) / 15, reciprocal floor(2^16 / 15)
    localparam logic [12:0] MIN_RECIP  = 13'd4369;
    localparam logic [5:0]  SECS_MIN   = 6'd60;

    // civil-from-days constants
    localparam logic [19:0] DAY_SHIFT  = 20'd719468;
    localparam logic [19:0] ERA_FOUR   = 20'd584388;  // 4 * 146097
    localparam logic [19:0] ERA_FIVE   = 20'd730485;  // 5 * 146097
    localparam logic [17:0] CENT_DAYS  = 18'd36524;
    localparam logic [17:0] ERA_LAST   = 18'd146096;
    localparam logic [8:0]  YEAR_DAYS  = 9'd365;
    localparam logic [7:0]  Q365_RECIP = 8'd179;      // floor(2^16 / 365)
    localparam logic [9:0]  YOE_RECIP  = 10'd718;     // floor(2^18 / 365)
    localparam logic [8:0]  MP_RECIP   = 9'd428;      // floor(2^16 / 153)
    localparam logic [7:0]  MP_DIV     = 8'd153;
    localparam logic [YEAR_W-1:0] YEAR_ERA4 = 12'd1600;
    localparam logic [YEAR_W-1:0] YEAR_ERA5 = 12'd2000;

    // time of day fields carried beside the date
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SECF_W-1:0] second;
    } t_tod;

    // first day of a march-based month within its year: (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/ustc_day_split.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ustc_day_split
// Two-stage split of a seconds count into whole days and seconds of the day,
// using a reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module ustc_day_split (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ustc_pkg::SEC_W-1:0]  i_seconds,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ustc_pkg::DAYS_W-1:0] o_days,
    output logic [ustc_pkg::TOD_W-1:0]  o_tod
);
    import ustc_pkg::*;

    localparam int NSTG = 2;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    // stage 0 registers
    logic [24:0]       r_x;
    logic [6:0]        r_lo;
    logic [DAYS_W-1:0] r_q;

    // stage 0 next values
    logic [50:0]       prod;
    logic [DAYS_W-1:0] n_q;

    // stage 1 next values
    logic [24:0]       qm;
    logic [10:0]       rem;
    logic              corr;
    logic [DAYS_W-1:0] n_days;
    logic [9:0]        n_rem;

    // stage 1 registers
    logic [DAYS_W-1:0] r_days;
    logic [TOD_W-1:0]  r_tod;

    // advance chain, a stage moves when empty or when the next one moves
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
        end
    end

    // stage 0: estimate of days from the reciprocal
    assign prod = 51'(i_seconds[31:7]) * 51'(DAY_RECIP);
    assign n_q  = prod[50:35];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_x  <= i_seconds[31:7];
            r_lo <= i_seconds[6:0];
            r_q  <= n_q;
        end
    end

    // stage 1: remainder and correction of the estimate
    assign qm     = 25'(r_q) * 25'(DAY_DIV);
    assign rem    = 11'(r_x - qm);
    assign corr   = rem >= 11'(DAY_DIV);
    assign n_days = r_q + DAYS_W'(corr);
    assign n_rem  = corr ? 10'(rem - 11'(DAY_DIV)) : rem[9:0];

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_days <= n_days;
            r_tod  <= {n_rem, r_lo};
        end
    end

    assign o_days = r_days;
    assign o_tod  = r_tod;

endmodule

/* src/ustc_tod_split.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ustc_tod_split
// Four-stage split of seconds of the day into hour, minute and second; the
// day count rides along for the date stages.
// ----------------------------------------------------------------------------
module ustc_tod_split (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ustc_pkg::DAYS_W-1:0] i_days,
    input  logic [ustc_pkg::TOD_W-1:0]  i_tod,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ustc_pkg::DAYS_W-1:0] o_days,
    output ustc_pkg::t_tod              o_tod
);
    import ustc_pkg::*;

    localparam int NSTG = 4;

    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   adv;
    logic [DAYS_W-1:0] r_days [NSTG];

    // stage 0
    logic [21:0]       hprod;
    logic [HOUR_W-1:0] n_h_est;
    logic [TOD_W-1:0]  r_tod0;
    logic [HOUR_W-1:0] r_h_est;

    // stage 1
    logic [TOD_W-1:0]  hm;
    logic [12:0]       hrem;
    logic              hcorr;
    logic [HOUR_W-1:0] n_hour;
    logic [11:0]       n_rem;
    logic [HOUR_W-1:0] r_hour1;
    logic [11:0]       r_rem1;

    // stage 2
    logic [22:0]       mprod;
    logic [MIN_W-1:0]  n_m_est;
    logic [HOUR_W-1:0] r_hour2;
    logic [11:0]       r_rem2;
    logic [MIN_W-1:0]  r_m_est;

    // stage 3
    logic [11:0]       mm;
    logic [6:0]        mrem;
    logic              mcorr;
    t_tod              n_out;
    t_tod              r_out;

    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // day count travels with the request
    always_ff @(posedge i_clk) begin
        if (adv[0]) r_days[0] <= i_days;
        for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) r_days[k] <= r_days[k-1];
        end
    end

    // stage 0: hour estimate
    assign hprod   = 22'(i_tod[16:4]) * 22'(HOUR_RECIP);
    assign n_h_est = hprod[20:16];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_tod0  <= i_tod;
            r_h_est <= n_h_est;
        end
    end

    // stage 1: hour correction, seconds within the hour
    assign hm     = 17'(r_h_est) * 17'(SECS_HOUR);
    assign hrem   = 13'(r_tod0 - hm);
    assign hcorr  = hrem >= 13'(SECS_HOUR);
    assign n_hour = r_h_est + HOUR_W'(hcorr);
    assign n_rem  = hcorr ? 12'(hrem - 13'(SECS_HOUR)) : hrem[11:0];

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_hour1 <= n_hour;
            r_rem1  <= n_rem;
        end
    end

    // stage 2: minute estimate
    assign mprod   = 23'(r_rem1[11:2]) * 23'(MIN_RECIP);
    assign n_m_est = mprod[21:16];

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_hour2 <= r_hour1;
            r_rem2  <= r_rem1;
            r_m_est <= n_m_est;
        end
    end

    // stage 3: minute correction and second
    assign mm    = 12'(r_m_est) * 12'(SECS_MIN);
    assign mrem  = 7'(r_rem2 - mm);
    assign mcorr = mrem >= 7'(SECS_MIN);

    always_comb begin
        n_out.hour   = r_hour2;
        n_out.minute = r_m_est + MIN_W'(mcorr);
        n_out.second = mcorr ? 6'(mrem - 7'(SECS_MIN)) : mrem[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) r_out <= n_out;
    end

    assign o_days = r_days[NSTG-1];
    assign o_tod  = r_out;

endmodule

/* src/ustc_civil_date.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ustc_civil_date
// Eight-stage civil-from-days conversion: era, day of era, year of era,
// day of a march-based year, then month, day and year. Time of day fields
// ride along.
// ----------------------------------------------------------------------------
module ustc_civil_date (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ustc_pkg::DAYS_W-1:0] i_days,
    input  ustc_pkg::t_tod              i_tod,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ustc_pkg::YEAR_W-1:0] o_year,
    output logic [ustc_pkg::MON_W-1:0]  o_month,
    output logic [ustc_pkg::DOM_W-1:0]  o_day_of_month,
    output ustc_pkg::t_tod              o_tod
);
    import ustc_pkg::*;

    localparam int NSTG = 8;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;
    t_tod            r_tod [NSTG];
    logic            r_era5 [NSTG-1];

    // stage 0
    logic [19:0] z;
    logic        n_era5;
    logic [17:0] n_doe;
    logic [17:0] r_doe0;

    // stage 1
    logic [23:0] qprod;
    logic [6:0]  n_q1460;
    logic [17:0] r_doe1;
    logic [6:0]  r_q1460;

    // stage 2
    logic [15:0] qm;
    logic [9:0]  qrem;
    logic [6:0]  a1460;
    logic [2:0]  b36524;
    logic        c146096;
    logic [17:0] n_t;
    logic [17:0] r_doe2;
    logic [17:0] r_t2;

    // stage 3
    logic [27:0] yprod;
    logic [8:0]  n_y_est;
    logic [17:0] r_doe3;
    logic [17:0] r_t3;
    logic [8:0]  r_y_est;

    // stage 4
    logic [17:0] ym;
    logic [9:0]  yrem;
    logic [8:0]  n_yoe;
    logic [17:0] r_doe4;
    logic [8:0]  r_yoe4;

    // stage 5
    logic [1:0]  c100;
    logic [17:0] ybase;
    logic [8:0]  n_doy;
    logic [8:0]  r_yoe5;
    logic [8:0]  r_doy5;

    // stage 6
    logic [10:0] v6;
    logic [19:0] mprod;
    logic [3:0]  n_mp_est;
    logic [8:0]  r_yoe6;
    logic [8:0]  r_doy6;
    logic [3:0]  r_mp_est;

    // stage 7
    logic [10:0]       v7;
    logic [11:0]       mpm;
    logic [10:0]       mprem;
    logic [3:0]        mp;
    logic [MON_W-1:0]  n_mon;
    logic [DOM_W-1:0]  n_dom;
    logic [YEAR_W-1:0] n_year;
    logic [YEAR_W-1:0] r_year;
    logic [MON_W-1:0]  r_mon;
    logic [DOM_W-1:0]  r_dom;

    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // time of day and era travel with the request
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_tod[0]  <= i_tod;
            r_era5[0] <= n_era5;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) r_tod[k] <= r_tod[k-1];
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (adv[k]) r_era5[k] <= r_era5[k-1];
        end
    end

    // stage 0: shift to the march epoch, era is four or five
    assign z      = 20'(i_days) + DAY_SHIFT;
    assign n_era5 = z >= ERA_FIVE;
    assign n_doe  = 18'(z - (n_era5 ? ERA_FIVE : ERA_FOUR));

    always_ff @(posedge i_clk) begin
        if (adv[0]) r_doe0 <= n_doe;
    end

    // stage 1: estimate of doe / 1460 as (doe >> 2) / 365
    assign qprod   = 24'(r_doe0[17:2]) * 24'(Q365_RECIP);
    assign n_q1460 = qprod[22:16];

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_doe1  <= r_doe0;
            r_q1460 <= n_q1460;
        end
    end

    // stage 2: correct the leap count, century and era-end terms
    assign qm      = 16'(r_q1460) * 16'(YEAR_DAYS);
    assign qrem    = 10'(r_doe1[17:2] - qm);
    assign a1460   = r_q1460 + 7'(qrem >= 10'(YEAR_DAYS));
    assign b36524  = 3'(r_doe1 >= CENT_DAYS) + 3'(r_doe1 >= 18'(2 * 36524))
                   + 3'(r_doe1 >= 18'(3 * 36524)) + 3'(r_doe1 >= ERA_LAST);
    assign c146096 = r_doe1 == ERA_LAST;
    assign n_t     = r_doe1 - 18'(a1460) + 18'(b36524) - 18'(c146096);

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_doe2 <= r_doe1;
            r_t2   <= n_t;
        end
    end

    // stage 3: year of era estimate
    assign yprod   = 28'(r_t2) * 28'(YOE_RECIP);
    assign n_y_est = yprod[26:18];

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_doe3  <= r_doe2;
            r_t3    <= r_t2;
            r_y_est <= n_y_est;
        end
    end

    // stage 4: year of era correction
    assign ym    = 18'(r_y_est) * 18'(YEAR_DAYS);
    assign yrem  = 10'(r_t3 - ym);
    assign n_yoe = r_y_est + 9'(yrem >= 10'(YEAR_DAYS));

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_doe4 <= r_doe3;
            r_yoe4 <= n_yoe;
        end
    end

    // stage 5: day of the march-based year
    assign c100  = 2'(r_yoe4 >= 9'd100) + 2'(r_yoe4 >= 9'd200) + 2'(r_yoe4 >= 9'd300);
    assign ybase = 18'(r_yoe4) * 18'(YEAR_DAYS) + 18'(r_yoe4[8:2]) - 18'(c100);
    assign n_doy = 9'(r_doe4 - ybase);

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_yoe5 <= r_yoe4;
            r_doy5 <= n_doy;
        end
    end

    // stage 6: march-based month estimate
    assign v6       = 11'(r_doy5) * 11'd5 + 11'd2;
    assign mprod    = 20'(v6) * 20'(MP_RECIP);
    assign n_mp_est = mprod[19:16];

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_yoe6   <= r_yoe5;
            r_doy6   <= r_doy5;
            r_mp_est <= n_mp_est;
        end
    end

    // stage 7: month correction, day, calendar month and year
    assign v7    = 11'(r_doy6) * 11'd5 + 11'd2;
    assign mpm   = 12'(r_mp_est) * 12'(MP_DIV);
    assign mprem = 11'(12'(v7) - mpm);
    assign mp    = r_mp_est + 4'(mprem >= 11'(MP_DIV));
    assign n_dom = DOM_W'(r_doy6 - month_start(mp) + 9'd1);
    assign n_mon = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    assign n_year = 12'(r_yoe6) + (r_era5[NSTG-2] ? YEAR_ERA5 : YEAR_ERA4)
                  + 12'(n_mon <= 4'd2);

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_year <= n_year;
            r_mon  <= n_mon;
            r_dom  <= n_dom;
        end
    end

    assign o_year         = r_year;
    assign o_month        = r_mon;
    assign o_day_of_month = r_dom;
    assign o_tod          = r_tod[NSTG-1];

endmodule

/* src/unix_seconds_to_civil_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_seconds_to_civil_top
// Converts unsigned seconds since 1970-01-01 00:00:00 into a Gregorian date
// and time of day.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_seconds_since_epoch. A request is
//   taken at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with year, month, day, hour, minute and
//   second. A result is taken at a rising edge with o_valid high and i_stall
//   low; one result per request, in order.
//   The path runs through the day split, the time of day split and the civil
//   date stages. Each stage holds one request, so one request enters every
//   cycle while the output side takes results.
//   When i_stall is high the last stage holds its result; earlier stages keep
//   moving into empty slots, so o_stall rises only once all 14 stages are
//   full. Nothing is lost or repeated under stall.
//   Synchronous active-low reset empties the pipeline; there is no other
//   state and no configuration.
// ----------------------------------------------------------------------------
module unix_seconds_to_civil_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ustc_pkg::SEC_W-1:0]  i_seconds_since_epoch,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ustc_pkg::YEAR_W-1:0] o_year,
    output logic [ustc_pkg::MON_W-1:0]  o_month,
    output logic [ustc_pkg::DOM_W-1:0]  o_day_of_month,
    output logic [ustc_pkg::HOUR_W-1:0] o_hour,
    output logic [ustc_pkg::MIN_W-1:0]  o_minute,
    output logic [ustc_pkg::SECF_W-1:0] o_second
);
    import ustc_pkg::*;

    // day split to time of day split
    logic              ds_valid;
    logic              ds_stall;
    logic [DAYS_W-1:0] ds_days;
    logic [TOD_W-1:0]  ds_tod;

    // time of day split to date stages
    logic              ts_valid;
    logic              ts_stall;
    logic [DAYS_W-1:0] ts_days;
    t_tod              ts_tod;

    t_tod              out_tod;

    // seconds into days and seconds of the day
    ustc_day_split u_day_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_seconds (i_seconds_since_epoch),
        .o_valid   (ds_valid),
        .i_stall   (ds_stall),
        .o_days    (ds_days),
        .o_tod     (ds_tod)
    );

    // seconds of the day into hour, minute, second
    ustc_tod_split u_tod_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ds_valid),
        .o_stall (ds_stall),
        .i_days  (ds_days),
        .i_tod   (ds_tod),
        .o_valid (ts_valid),
        .i_stall (ts_stall),
        .o_days  (ts_days),
        .o_tod   (ts_tod)
    );

    // days into year, month, day
    ustc_civil_date u_civil_date (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (ts_valid),
        .o_stall        (ts_stall),
        .i_days         (ts_days),
        .i_tod          (ts_tod),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_tod          (out_tod)
    );

    assign o_hour   = out_tod.hour;
    assign o_minute = out_tod.minute;
    assign o_second = out_tod.second;

endmodule

/* verif/unix_seconds_to_civil_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_seconds_to_civil_top_tb
// Self-checking bench for the seconds-to-civil converter. Timestamps are
// driven through the valid/stall request channel with random gaps. Results
// are taken under random receiver stall and checked field by field, in
// order, against a calendar predictor built into the bench.
// ----------------------------------------------------------------------------
module unix_seconds_to_civil_top_tb;

    import ustc_pkg::*;

    localparam int CLK_HI      = 6;
    localparam int CLK_LO      = 6;
    localparam int RESET_CYC   = 11;
    localparam int PIPE_DEPTH  = 14;
    localparam int RANDOM_REQS = 900;

    // expected calendar fields for one timestamp
    typedef struct {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DOM_W-1:0]  dom;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SECF_W-1:0] second;
    } t_civil;

    // one pending request with its lead-in gap
    typedef struct {
        logic [SEC_W-1:0] stamp;
        int unsigned      gap;
        bit               drain_first;
    } t_stamp_req;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [SEC_W-1:0]   i_seconds_since_epoch;
    logic               o_valid;
    logic               i_stall;
    logic [YEAR_W-1:0]  o_year;
    logic [MON_W-1:0]   o_month;
    logic [DOM_W-1:0]   o_day_of_month;
    logic [HOUR_W-1:0]  o_hour;
    logic [MIN_W-1:0]   o_minute;
    logic [SECF_W-1:0]  o_second;

    t_stamp_req  stamp_pending_q[$];
    t_civil      civil_due_q[$];

    int unsigned reqs_issued  = 0;
    int unsigned reqs_taken   = 0;
    int unsigned dates_taken  = 0;
    int unsigned drain_pauses = 0;
    int unsigned error_count  = 0;

    unix_seconds_to_civil_top uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_seconds_since_epoch (i_seconds_since_epoch),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_year                (o_year),
        .o_month               (o_month),
        .o_day_of_month        (o_day_of_month),
        .o_hour                (o_hour),
        .o_minute              (o_minute),
        .o_second              (o_second)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #CLK_LO i_clk = 1'b1;
        #CLK_HI i_clk = 1'b0;
    end

    // calendar predictor: day split, then era / day of era with march years
    function automatic t_civil civil_from_stamp(input logic [SEC_W-1:0] stamp);
        int unsigned days, tod, z, era, doe, yoe, doy, mp, dom, mon, yr;
        t_civil      c;
        days = stamp / 86400;
        tod  = stamp % 86400;
        z    = days + 719468;
        era  = z / 146097;
        doe  = z - era * 146097;
        yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp   = (5 * doy + 2) / 153;
        dom  = doy - (153 * mp + 2) / 5 + 1;
        mon  = (mp < 10) ? mp + 3 : mp - 9;
        yr   = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
        c.year   = yr[YEAR_W-1:0];
        c.month  = mon[MON_W-1:0];
        c.dom    = dom[DOM_W-1:0];
        c.hour   = HOUR_W'(tod / 3600);
        c.minute = MIN_W'((tod % 3600) / 60);
        c.second = SECF_W'(tod % 60);
        return c;
    endfunction

    // queue one timestamp with its lead-in gap
    task automatic add_stamp(input logic [SEC_W-1:0] stamp, input int unsigned gap,
                             input bit drain_first);
        t_stamp_req r;
        r.stamp       = stamp;
        r.gap         = gap;
        r.drain_first = drain_first;
        stamp_pending_q.push_back(r);
    endtask

    // request driver, changes inputs at the falling edge
    int unsigned gap_left   = 0;
    bit          gap_loaded = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && reqs_taken != reqs_issued) begin
            // stalled request holds
        end else begin
            if (!gap_loaded && stamp_pending_q.size() != 0) begin
                gap_left   = stamp_pending_q[0].gap;
                gap_loaded = 1'b1;
                if (stamp_pending_q[0].drain_first) drain_pauses++;
            end
            if (gap_left != 0 || stamp_pending_q.size() == 0 ||
                (stamp_pending_q[0].drain_first && civil_due_q.size() != 0)) begin
                i_valid <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                i_valid               <= 1'b1;
                i_seconds_since_epoch <= stamp_pending_q[0].stamp;
                void'(stamp_pending_q.pop_front());
                reqs_issued++;
                gap_loaded = 1'b0;
            end
        end
    end

    // receiver stall, a fresh wait drawn for each result; a calm stretch has none
    int unsigned stall_left = 0;
    int unsigned stall_ref  = 0;
    always @(negedge i_clk) begin
        if (stall_ref != dates_taken) begin
            stall_ref  = dates_taken;
            stall_left = (dates_taken >= 300 && dates_taken < 420) ? 0 : $urandom_range(0, 4);
        end
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: check results in order, then record accepted requests
    always @(posedge i_clk) begin
        t_civil want;
        if (i_rst_n && o_valid && !i_stall) begin
            dates_taken++;
            if (civil_due_q.size() == 0) begin
                $error("result with no request outstanding: %0d-%0d-%0d", o_year, o_month,
                       o_day_of_month);
                error_count++;
            end else begin
                want = civil_due_q.pop_front();
                if (o_year !== want.year) begin
                    $error("year expected %0d actual %0d", want.year, o_year);
                    error_count++;
                end
                if (o_month !== want.month) begin
                    $error("month expected %0d actual %0d", want.month, o_month);
                    error_count++;
                end
                if (o_day_of_month !== want.dom) begin
                    $error("day_of_month expected %0d actual %0d", want.dom, o_day_of_month);
                    error_count++;
                end
                if (o_hour !== want.hour) begin
                    $error("hour expected %0d actual %0d", want.hour, o_hour);
                    error_count++;
                end
                if (o_minute !== want.minute) begin
                    $error("minute expected %0d actual %0d", want.minute, o_minute);
                    error_count++;
                end
                if (o_second !== want.second) begin
                    $error("second expected %0d actual %0d", want.second, o_second);
                    error_count++;
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            civil_due_q.push_back(civil_from_stamp(i_seconds_since_epoch));
            reqs_taken++;
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned kind, gap, day;
        logic [SEC_W-1:0] stamp;
        i_rst_n               = 1'b0;
        i_valid               = 1'b0;
        i_stall               = 1'b0;
        i_seconds_since_epoch = '0;

        // directed: field extremes, day and minute edges, leap days, top of range
        add_stamp(32'd0,          0, 1'b0);
        add_stamp(32'd1,          0, 1'b0);
        add_stamp(32'd59,         1, 1'b0);
        add_stamp(32'd60,         0, 1'b0);
        add_stamp(32'd3599,       0, 1'b0);
        add_stamp(32'd3600,       2, 1'b0);
        add_stamp(32'd86399,      0, 1'b0);
        add_stamp(32'd86400,      0, 1'b0);
        add_stamp(32'd68169600,   0, 1'b0);  // 1972 leap day
        add_stamp(32'd946684799,  3, 1'b0);  // last second of 1999
        add_stamp(32'd946684800,  0, 1'b0);
        add_stamp(32'd951782400,  0, 1'b0);  // leap day of a 400 year
        add_stamp(32'd951868800,  0, 1'b0);
        add_stamp(32'd2147483647, 4, 1'b0);
        add_stamp(32'd2147483648, 0, 1'b0);
        add_stamp(32'd4107542399, 0, 1'b0);  // 2100 is no leap year
        add_stamp(32'd4107542400, 0, 1'b0);
        add_stamp(32'h5555_5555,  1, 1'b0);
        add_stamp(32'hAAAA_AAAA,  0, 1'b0);
        add_stamp(32'hFFFF_FFFE,  0, 1'b0);
        add_stamp(32'hFFFF_FFFF,  0, 1'b0);

        // random: uniform, day edges, very early and very late stamps
        for (int n = 0; n < RANDOM_REQS; n++) begin
            kind = $urandom_range(0, 99);
            day  = $urandom_range(0, 49710);
            if (kind < 50) begin
                stamp = $urandom();
            end else if (kind < 75) begin
                stamp = day * 86400 + (($urandom_range(0, 1) != 0) ? 86399 :
                                       $urandom_range(0, 3));
            end else if (kind < 88) begin
                stamp = $urandom_range(0, 40_000_000);
            end else begin
                stamp = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
            end
            gap = (n >= 200 && n < 320) ? 0 : $urandom_range(0, 4);
            add_stamp(stamp, gap, (n == 0) || (n == 450) || (n == 700));
        end

        repeat (RESET_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // drain, then let the pipeline settle to catch any extra result
        do @(posedge i_clk);
        while (stamp_pending_q.size() != 0 || reqs_taken != reqs_issued ||
               civil_due_q.size() != 0);
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);

        $display("converted %0d timestamps into %0d dates, %0d drain pauses",
                 reqs_taken, dates_taken, drain_pauses);
        $display("covered epoch start, day and minute edges, leap days and the 32-bit top");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
